@@ rtl/core/pmmp_pkg.sv @@
// Package for the page min/max pruner: shared codes, defaults and the
// controller/datapath command and status structs. No dependencies.
package pmmp_pkg;

  localparam int unsigned MAX_NEEDLES_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 20;

  localparam int unsigned NeedleW  = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PrunedW  = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpAdd   = 2'd1,
    OpEval  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgQueryKind  = 3'd0,
    CfgValueType  = 3'd1,
    CfgUnsigned   = 3'd2,
    CfgBounds     = 3'd3,
    CfgNullFlags  = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] QkInteger = 2'd0;
  localparam logic [1:0] VtInt32   = 2'd0;
  localparam logic [1:0] VtInt64   = 2'd1;

  localparam logic [LenW-1:0] Int32Len = 4'd4;
  localparam logic [LenW-1:0] Int64Len = 4'd8;

  typedef struct packed {
    logic load;
    logic decode;
    logic scan_step;
    logic finish;
    logic fin_keep;
  } pmmp_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic early_keep;
    logic hit;
    logic last_entry;
  } pmmp_status_t;

endpackage

@@ rtl/core/pmmp_ctrl.sv @@
// Controller for the page min/max pruner: sequences decode and needle scan.
// Depends on pmmp_pkg.
module pmmp_ctrl
  import pmmp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  pmmp_status_t status_i,
  output pmmp_cmd_t    cmd_o,
  output logic         busy_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDecode,
    StScan
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_d  = busy_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
          busy_d     = 1'b1;
        end
      end
      StDecode: begin
        cmd_o.decode = 1'b1;
        if (status_i.scan_needed) begin
          state_d = StScan;
        end else begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_keep = status_i.early_keep;
          state_d        = StIdle;
          busy_d         = 1'b0;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.hit || status_i.last_entry) begin
          cmd_o.finish   = 1'b1;
          cmd_o.fin_keep = status_i.hit;
          state_d        = StIdle;
          busy_d         = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

`ifndef SYNTHESIS
  a_finish_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> busy_q)
    else $error("finish issued while idle");

  a_load_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy_q && cmd_o.decode)
    else $error("accepted transaction not followed by decode");

  a_finish_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_q && !cmd_o.scan_step)
    else $error("controller still busy after finish");
`endif

endmodule

@@ rtl/core/pmmp_datapath.sv @@
// Datapath for the page min/max pruner: config registers, bound decode,
// needle memory, scan compare and result registers. Depends on pmmp_pkg.
module pmmp_datapath
  import pmmp_pkg::*;
#(
  parameter int unsigned MAX_NEEDLES = MAX_NEEDLES_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  pmmp_cmd_t           cmd_i,
  output pmmp_status_t        status_o,
  input  logic [1:0]          op_i,
  input  logic [NeedleW-1:0]  needle_value_i,
  input  logic                page_is_null_i,
  input  logic [LenW-1:0]     min_length_i,
  input  logic [NeedleW-1:0]  min_bytes_i,
  input  logic [LenW-1:0]     max_length_i,
  input  logic [NeedleW-1:0]  max_bytes_i,
  input  logic                last_page_i,
  output logic                done_o,
  output logic                keep_page_o,
  output logic [PrunedW-1:0]  pruned_total_o,
  output logic                drop_flag_o,
  output logic                final_page_o
);

  localparam int unsigned CntW = $clog2(MAX_NEEDLES + 1);
  localparam int unsigned IdxW = (MAX_NEEDLES > 1) ? $clog2(MAX_NEEDLES) : 1;
  localparam int unsigned ExtW = (COUNT_BITS > PrunedW) ? COUNT_BITS : PrunedW;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // configuration
  logic [1:0] query_kind_q, value_type_q;
  logic       unsigned_q, bounds_q, null_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_kind_q <= '0;
      value_type_q <= '0;
      unsigned_q   <= 1'b0;
      bounds_q     <= 1'b0;
      null_flags_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgQueryKind: query_kind_q <= cfg_data_i[1:0];
        CfgValueType: value_type_q <= cfg_data_i[1:0];
        CfgUnsigned:  unsigned_q   <= cfg_data_i[0];
        CfgBounds:    bounds_q     <= cfg_data_i[0];
        CfgNullFlags: null_flags_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // transaction payload
  logic [1:0]         op_q;
  logic [NeedleW-1:0] needle_q, min_bytes_q, max_bytes_q;
  logic [LenW-1:0]    min_len_q, max_len_q;
  logic               null_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= op_i;
      needle_q    <= needle_value_i;
      null_q      <= page_is_null_i;
      min_len_q   <= min_length_i;
      min_bytes_q <= min_bytes_i;
      max_len_q   <= max_length_i;
      max_bytes_q <= max_bytes_i;
      last_q      <= last_page_i;
    end
  end

  // control state
  logic [CntW-1:0]       count_q, idx_q;
  logic [COUNT_BITS-1:0] cnt_q;

  // bound decode
  logic [NeedleW-1:0] lo_d, hi_d, lo_q, hi_q;
  logic               lo_ok, hi_ok, lo_ovf, hi_ovf, hi_ovf_q;
  logic               scan_needed, early_keep;

  always_comb begin
    lo_d   = {{32{min_bytes_q[31] & ~unsigned_q}}, min_bytes_q[31:0]};
    hi_d   = {{32{max_bytes_q[31] & ~unsigned_q}}, max_bytes_q[31:0]};
    lo_ok  = (min_len_q == Int32Len);
    hi_ok  = (max_len_q == Int32Len);
    lo_ovf = 1'b0;
    hi_ovf = 1'b0;
    if (value_type_q == VtInt64) begin
      lo_d   = min_bytes_q;
      hi_d   = max_bytes_q;
      lo_ok  = (min_len_q == Int64Len);
      hi_ok  = (max_len_q == Int64Len);
      lo_ovf = unsigned_q & min_bytes_q[NeedleW-1];
      hi_ovf = unsigned_q & max_bytes_q[NeedleW-1];
    end
  end

  always_comb begin
    scan_needed = 1'b0;
    early_keep  = 1'b1;
    priority if (op_q != OpEval) begin
      early_keep = 1'b0;
    end else if (null_flags_q && null_q) begin
      early_keep = 1'b0;
    end else if (!bounds_q || query_kind_q != QkInteger || count_q == '0) begin
      early_keep = 1'b1;
    end else if (value_type_q != VtInt32 && value_type_q != VtInt64) begin
      early_keep = 1'b1;
    end else if (!lo_ok || !hi_ok || lo_ovf) begin
      early_keep = 1'b1;
    end else begin
      scan_needed = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      hi_ovf_q <= hi_ovf;
    end
  end

  // needle memory, one read per cycle
  logic [NeedleW-1:0] mem [MAX_NEEDLES];
  logic [NeedleW-1:0] rd_q;
  logic [IdxW-1:0]    rd_addr;
  logic               add_ok;

  assign add_ok  = (count_q < CntW'(MAX_NEEDLES));
  assign rd_addr = (cmd_i.decode || idx_q >= CntW'(MAX_NEEDLES)) ? '0 : idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && op_q == OpAdd && add_ok) begin
      mem[count_q[IdxW-1:0]] <= needle_q;
    end
    rd_q <= mem[rd_addr];
  end

  logic scan_hit, scan_last;

  assign scan_hit  = ($signed(lo_q) <= $signed(rd_q)) &&
                     (hi_ovf_q || ($signed(rd_q) <= $signed(hi_q)));
  assign scan_last = (idx_q == count_q);

  assign status_o = '{scan_needed: scan_needed, early_keep: early_keep,
                      hit: scan_hit, last_entry: scan_last};

  // results and counters
  logic done_q, keep_q, stat_q, fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.decode) begin
        idx_q <= CntW'(1);
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        unique case (op_q)
          OpClear: begin
            count_q <= '0;
            cnt_q   <= '0;
          end
          OpAdd: begin
            if (add_ok) count_q <= count_q + CntW'(1);
          end
          OpEval: begin
            if (!cmd_i.fin_keep && cnt_q != CountMax) cnt_q <= cnt_q + COUNT_BITS'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      keep_q <= (op_q == OpEval) && cmd_i.fin_keep;
      fin_q  <= (op_q == OpEval) && last_q;
      stat_q <= (op_q == OpAdd) && !add_ok;
    end
  end

  logic [ExtW-1:0] cnt_ext;
  assign cnt_ext = ExtW'(cnt_q);

  assign done_o         = done_q;
  assign keep_page_o    = keep_q;
  assign drop_flag_o    = stat_q;
  assign final_page_o   = fin_q;
  assign pruned_total_o = cnt_ext[PrunedW-1:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_NEEDLES))
    else $error("needle count beyond table depth");

  a_counter_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && op_q != OpClear) |-> (cnt_q >= $past(cnt_q)))
    else $error("pruned counter fell without a clear");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(keep_q && stat_q))
    else $error("kept page and dropped needle in one result");
`endif

endmodule

@@ rtl/core/page_min_max_pruner_top.sv @@
// Top level of the page min/max pruner: controller plus datapath.
// Depends on pmmp_pkg, pmmp_ctrl and pmmp_datapath.
//
// A transaction is taken when start_i is high and busy_o low; its result is
// shown for one cycle with done_o high and cannot be held off. Clear, add
// and pages settled without a scan pass through the decode state only; a
// page that needs a scan then reads needles until a hit or the end of the
// table, and no new transaction is taken until the current one finishes.
// The scan reads the needle memory through its single read port, one entry
// a cycle. Configuration writes are always ready and must be made while idle.
module page_min_max_pruner_top
  import pmmp_pkg::*;
#(
  parameter int unsigned MAX_NEEDLES = MAX_NEEDLES_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          op_i,
  input  logic [NeedleW-1:0]  needle_value_i,
  input  logic                page_is_null_i,
  input  logic [LenW-1:0]     min_length_i,
  input  logic [NeedleW-1:0]  min_bytes_i,
  input  logic [LenW-1:0]     max_length_i,
  input  logic [NeedleW-1:0]  max_bytes_i,
  input  logic                last_page_i,
  output logic                done_o,
  output logic                keep_page_o,
  output logic [PrunedW-1:0]  pruned_total_o,
  output logic                status_o,
  output logic                final_page_o
);

  pmmp_cmd_t    cmd;
  pmmp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  pmmp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  pmmp_datapath #(
    .MAX_NEEDLES (MAX_NEEDLES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .op_i           (op_i),
    .needle_value_i (needle_value_i),
    .page_is_null_i (page_is_null_i),
    .min_length_i   (min_length_i),
    .min_bytes_i    (min_bytes_i),
    .max_length_i   (max_length_i),
    .max_bytes_i    (max_bytes_i),
    .last_page_i    (last_page_i),
    .done_o         (done_o),
    .keep_page_o    (keep_page_o),
    .pruned_total_o (pruned_total_o),
    .drop_flag_o    (status_o),
    .final_page_o   (final_page_o)
  );

endmodule
